@@ rtl/jsu_pkg.sv @@
// Package: decode modes, status codes, bundle type and helper functions.
package jsu_pkg;

  typedef enum logic [3:0] {
    MODE_NORMAL  = 4'd0,
    MODE_FRESH   = 4'd1,
    MODE_ESC     = 4'd2,
    MODE_HEX1    = 4'd3,
    MODE_HEX2    = 4'd4,
    MODE_HEX3    = 4'd5,
    MODE_HEX4    = 4'd6,
    MODE_SURR_BS = 4'd7,
    MODE_SURR_U  = 4'd8,
    MODE_LOW1    = 4'd9,
    MODE_LOW2    = 4'd10,
    MODE_LOW3    = 4'd11,
    MODE_LOW4    = 4'd12,
    MODE_DROP    = 4'd13
  } jsu_mode_t;

  localparam logic [2:0] ST_BYTE     = 3'd0;
  localparam logic [2:0] ST_CLOSED   = 3'd1;
  localparam logic [2:0] ST_CTRL     = 3'd2;
  localparam logic [2:0] ST_BAD_ESC  = 3'd3;
  localparam logic [2:0] ST_BAD_UNI  = 3'd4;
  localparam logic [2:0] ST_UNTERM   = 3'd5;

  localparam logic [15:0] SURR_HI_LO = 16'hd800;
  localparam logic [15:0] SURR_HI_HI = 16'hdbff;
  localparam logic [15:0] SURR_LO_LO = 16'hdc00;
  localparam logic [15:0] SURR_LO_HI = 16'hdfff;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  // Results of one input byte: up to four bytes, one status for all.
  typedef struct packed {
    logic [2:0]       cnt;
    logic [2:0]       status;
    logic [3:0][7:0]  bytes;
  } jsu_bundle_t;

  // Bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) v = {1'b0, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      v = {1'b0, b[3:0] + 4'd9};
    return v;
  endfunction

  function automatic jsu_bundle_t utf8_encode(input logic [20:0] cp);
    jsu_bundle_t r;
    r = '0;
    r.status = ST_BYTE;
    if (cp <= 21'h7f) begin
      r.cnt = 3'd1;
      r.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp <= 21'h7ff) begin
      r.cnt = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hffff) begin
      r.cnt = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.cnt = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

@@ rtl/jsu_in_if.sv @@
// Input channel: raw string-body bytes.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

@@ rtl/jsu_out_if.sv @@
// Result channel: decoded UTF-8 bytes and status.
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last_of_run;

  modport source (output valid, output out_byte, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input status, input last_of_run,
                  output ready);
endinterface

@@ rtl/jsu_decoder.sv @@
// Escape decoder: mode state and the result bundle for one input byte.
module jsu_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          in_byte,
  input  logic                end_of_text,
  output jsu_pkg::jsu_bundle_t bundle
);
  import jsu_pkg::*;

  jsu_mode_t   mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [9:0]  hsb_r, hsb_nxt;
  logic [4:0]  hv;
  logic [15:0] acc_sh;
  logic [20:0] pair_cp;
  logic        acc_is_hi;
  logic        acc_is_lo;

  assign hv        = hex_value(in_byte);
  assign acc_sh    = {acc_r[11:0], hv[3:0]};
  assign pair_cp   = SUPP_BASE + {1'b0, hsb_r, acc_sh[9:0]};
  assign acc_is_hi = (acc_sh >= SURR_HI_LO) && (acc_sh <= SURR_HI_HI);
  assign acc_is_lo = (acc_sh >= SURR_LO_LO) && (acc_sh <= SURR_LO_HI);

  // next mode, hex accumulator and high surrogate bits
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    hsb_nxt  = hsb_r;
    if (end_of_text) begin
      mode_nxt = MODE_NORMAL;
    end else begin
      unique case (mode_r)
        MODE_DROP: ;
        MODE_ESC: begin
          unique case (in_byte)
            8'h75: begin
              acc_nxt  = '0;
              mode_nxt = MODE_HEX1;
            end
            8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74: begin
              mode_nxt = MODE_NORMAL;
            end
            default: begin
              mode_nxt = MODE_DROP;
            end
          endcase
        end
        MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4,
        MODE_LOW1, MODE_LOW2, MODE_LOW3, MODE_LOW4: begin
          if (hv[4]) begin
            mode_nxt = MODE_DROP;
          end else begin
            acc_nxt = acc_sh;
            if (mode_r == MODE_HEX4) begin
              if (acc_is_hi) begin
                hsb_nxt  = acc_sh[9:0];
                mode_nxt = MODE_SURR_BS;
              end else if (acc_is_lo) begin
                mode_nxt = MODE_DROP;
              end else begin
                mode_nxt = MODE_NORMAL;
              end
            end else if (mode_r == MODE_LOW4) begin
              if (acc_is_lo) mode_nxt = MODE_NORMAL;
              else mode_nxt = MODE_DROP;
            end else begin
              mode_nxt = jsu_mode_t'(mode_r + 4'd1);
            end
          end
        end
        MODE_SURR_BS: begin
          if (in_byte == 8'h5c) mode_nxt = MODE_SURR_U;
          else mode_nxt = MODE_DROP;
        end
        MODE_SURR_U: begin
          if (in_byte == 8'h75) begin
            acc_nxt  = '0;
            mode_nxt = MODE_LOW1;
          end else begin
            mode_nxt = MODE_DROP;
          end
        end
        default: begin
          // body text, also just after a close
          if (in_byte == 8'h22) mode_nxt = MODE_FRESH;
          else if (in_byte < 8'h20) mode_nxt = MODE_DROP;
          else if (in_byte == 8'h5c) mode_nxt = MODE_ESC;
          else mode_nxt = MODE_NORMAL;
        end
      endcase
    end
  end

  // result bundle for the current byte
  always_comb begin
    bundle = '0;
    if (end_of_text) begin
      unique case (mode_r)
        MODE_FRESH, MODE_DROP: ;
        MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4, MODE_SURR_BS, MODE_SURR_U,
        MODE_LOW1, MODE_LOW2, MODE_LOW3, MODE_LOW4: begin
          bundle.cnt = 3'd1; bundle.status = ST_BAD_UNI;
        end
        default: begin
          bundle.cnt = 3'd1; bundle.status = ST_UNTERM;
        end
      endcase
    end else begin
      unique case (mode_r)
        MODE_DROP: ;
        MODE_ESC: begin
          bundle.cnt = 3'd1;
          unique case (in_byte)
            8'h22, 8'h5c, 8'h2f: bundle.bytes[0] = in_byte;
            8'h62: bundle.bytes[0] = 8'h08;
            8'h66: bundle.bytes[0] = 8'h0c;
            8'h6e: bundle.bytes[0] = 8'h0a;
            8'h72: bundle.bytes[0] = 8'h0d;
            8'h74: bundle.bytes[0] = 8'h09;
            8'h75: bundle.cnt = 3'd0;
            default: bundle.status = ST_BAD_ESC;
          endcase
        end
        MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4,
        MODE_LOW1, MODE_LOW2, MODE_LOW3, MODE_LOW4: begin
          if (hv[4]) begin
            bundle.cnt = 3'd1; bundle.status = ST_BAD_UNI;
          end else if (mode_r == MODE_HEX4) begin
            if (acc_is_hi) begin
              bundle = '0;
            end else if (acc_is_lo) begin
              bundle.cnt = 3'd1; bundle.status = ST_BAD_UNI;
            end else begin
              bundle = utf8_encode({5'd0, acc_sh});
            end
          end else if (mode_r == MODE_LOW4) begin
            if (acc_is_lo) begin
              bundle = utf8_encode(pair_cp);
            end else begin
              bundle.cnt = 3'd1; bundle.status = ST_BAD_UNI;
            end
          end
        end
        MODE_SURR_BS: begin
          if (in_byte != 8'h5c) begin
            bundle.cnt = 3'd1; bundle.status = ST_BAD_UNI;
          end
        end
        MODE_SURR_U: begin
          if (in_byte != 8'h75) begin
            bundle.cnt = 3'd1; bundle.status = ST_BAD_UNI;
          end
        end
        default: begin
          if (in_byte == 8'h22) begin
            bundle.cnt = 3'd1; bundle.status = ST_CLOSED;
          end else if (in_byte < 8'h20) begin
            bundle.cnt = 3'd1; bundle.status = ST_CTRL;
          end else if (in_byte != 8'h5c) begin
            bundle.cnt      = 3'd1;
            bundle.bytes[0] = in_byte;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      acc_r  <= '0;
      hsb_r  <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      hsb_r  <= hsb_nxt;
    end
  end

endmodule

@@ rtl/jsu_serializer.sv @@
// Result register: holds one bundle and sends its bytes one beat each.
module jsu_serializer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  jsu_pkg::jsu_bundle_t bundle,
  output logic                 free,
  jsu_out_if.source            out_ch
);
  import jsu_pkg::*;

  logic        valid_r, valid_nxt;
  logic [1:0]  idx_r, idx_nxt;
  jsu_bundle_t bnd_r, bnd_nxt;
  logic        last;
  logic        take;

  assign last = ({1'b0, idx_r} == (bnd_r.cnt - 3'd1));
  assign take = valid_r && out_ch.ready;
  assign free = !valid_r || (take && last);

  assign out_ch.valid       = valid_r;
  assign out_ch.out_byte    = (bnd_r.status == ST_BYTE) ? bnd_r.bytes[idx_r] : 8'h00;
  assign out_ch.status      = bnd_r.status;
  assign out_ch.last_of_run = last;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    bnd_nxt   = bnd_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = '0;
      bnd_nxt   = bundle;
    end else if (take) begin
      if (last) valid_nxt = 1'b0;
      else idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
    bnd_r <= bnd_nxt;
  end

endmodule

@@ rtl/json_string_unescape_unit.sv @@
// Top level: JSON string body unescaper producing UTF-8 bytes.
//
// Takes one raw byte of a JSON string body per beat (starting after the
// opening quote) and returns decoded UTF-8 bytes, one per beat, each with a
// status and a last_of_run flag marking the final result of its input byte.
// Simple escapes and \uXXXX escapes (surrogate pairs joined into one 4-byte
// sequence) are decoded; a closing quote reports status 1 and the next byte
// starts a new string; errors report status 2..5 and then bytes are dropped
// until end_of_text. Timing: the first result of an input beat is offered
// the cycle after the beat is taken. An input beat is taken only while the
// result register is empty or handing over its last byte, so an input that
// yields N results (N = 1..4) holds off the next input until its last result
// is taken, and output stalls delay that further. Inputs that yield no
// result (backslash, hex digits) leave a gap on the output. With out ready
// held high, plain body bytes stream at one byte per cycle with no bubbles.
module json_string_unescape_unit (
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);
  import jsu_pkg::*;

  jsu_bundle_t bundle;
  logic        free;
  logic        step;

  // an input beat is taken whenever the result register is empty or about
  // to hand over its last byte
  assign in_ch.ready = free;
  assign step        = in_ch.valid && free;

  jsu_decoder u_decoder (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .in_byte     (in_ch.in_byte),
    .end_of_text (in_ch.end_of_text),
    .bundle      (bundle)
  );

  // bytes with no result only move the decoder state
  jsu_serializer u_serializer (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (step && (bundle.cnt != 3'd0)),
    .bundle (bundle),
    .free   (free),
    .out_ch (out_ch)
  );

endmodule
